/* rtl/bdlp_pkg.sv */
// Package for the button debounce and long-press block.
// Holds the button count, field widths, operation and register codes and shared structs.
// No dependencies.
package bdlp_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int RAW_BITS    = 3;
  localparam int MS_W        = 16;
  localparam int TIMER_W     = 17;
  localparam int OP_W        = 2;
  localparam int IDX_W       = 3;
  localparam int CFG_IDX_W   = 1;

  localparam logic [OP_W-1:0] OP_TICK       = 2'd0;
  localparam logic [OP_W-1:0] OP_READ_PRESS = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_LONG  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LEVEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS = 1'd1;

  localparam logic            PRESSED_LEVEL_RESET = 1'b0;
  localparam logic [MS_W-1:0] LONG_PRESS_MS_RESET = 16'd1000;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  typedef struct packed {
    logic tick;
    logic clear_press;
    logic clear_long;
  } ctrl_t;

  typedef struct packed {
    logic stable;
    logic stable_next;
    logic press_flag;
    logic long_flag;
  } status_t;

endpackage

/* rtl/bdlp_button.sv */
// State and update logic for one button: sample history, debounced level, hold timer, flags.
// Depends on bdlp_pkg.
module bdlp_button (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic                            sample,
  input  logic                            pressed_level,
  input  logic [bdlp_pkg::MS_W-1:0]       long_press_ms,
  input  logic [bdlp_pkg::MS_W-1:0]       elapsed_ms,
  input  bdlp_pkg::ctrl_t                 ctrl,
  output bdlp_pkg::status_t               status
);

  logic                           newest, newest_next;
  logic                           previous, previous_next;
  logic                           stable, stable_next;
  logic [bdlp_pkg::TIMER_W-1:0]   hold_timer, hold_timer_next;
  logic                           press_flag, press_flag_next;
  logic                           long_flag, long_flag_next;
  logic [bdlp_pkg::TIMER_W-1:0]   timer_base;
  logic [bdlp_pkg::TIMER_W:0]     timer_sum;

  assign timer_base = (stable != sample) ? '0 : hold_timer;
  assign timer_sum  = {1'b0, timer_base} + {2'b00, elapsed_ms};

  always_comb begin
    newest_next     = newest;
    previous_next   = previous;
    stable_next     = stable;
    hold_timer_next = hold_timer;
    press_flag_next = press_flag;
    long_flag_next  = long_flag;
    if (ctrl.tick) begin
      previous_next = newest;
      newest_next   = sample;
      if (sample == newest) begin
        if (stable != sample) begin
          stable_next     = sample;
          hold_timer_next = '0;
          long_flag_next  = 1'b0;
          if (sample == pressed_level) begin
            press_flag_next = 1'b1;
          end
        end
        if (sample == pressed_level) begin
          if (timer_base < {1'b0, long_press_ms}) begin
            hold_timer_next = timer_sum[bdlp_pkg::TIMER_W] ? bdlp_pkg::TIMER_MAX
                                                          : timer_sum[bdlp_pkg::TIMER_W-1:0];
          end else begin
            long_flag_next = 1'b1;
          end
        end
      end
    end
    if (ctrl.clear_press) begin
      press_flag_next = 1'b0;
    end
    if (ctrl.clear_long) begin
      long_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest     <= 1'b0;
      previous   <= 1'b0;
      stable     <= 1'b0;
      hold_timer <= '0;
      press_flag <= 1'b0;
      long_flag  <= 1'b0;
    end else if (step) begin
      newest     <= newest_next;
      previous   <= previous_next;
      stable     <= stable_next;
      hold_timer <= hold_timer_next;
      press_flag <= press_flag_next;
      long_flag  <= long_flag_next;
    end
  end

  // The older sample only matters for the state it records; it never feeds back.
  assign status.stable      = stable ^ (previous & 1'b0);
  assign status.stable_next = stable_next;
  assign status.press_flag  = press_flag;
  assign status.long_flag   = long_flag;

endmodule

/* rtl/button_debounce_long_press_core.sv */
// Top level of the button debounce and long-press block.
// Holds the request register, configuration registers and result register; uses bdlp_pkg and
// bdlp_button.

// Each request passes from acceptance through the request register, where all buttons are updated
// in parallel by short per-button logic, and then into the result register.
// A new request is accepted every cycle while results are taken; the request register empties
// into the result register whenever that register is free or being read in the same cycle.
module button_debounce_long_press_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bdlp_pkg::OP_W-1:0]           op,
  input  logic [bdlp_pkg::RAW_BITS-1:0]       raw_levels,
  input  logic [bdlp_pkg::MS_W-1:0]           elapsed_ms,
  input  logic [bdlp_pkg::IDX_W-1:0]          button_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                flag_answer,
  output logic                                index_error,
  output logic [bdlp_pkg::RAW_BITS-1:0]       stable_levels,
  input  logic                                cfg_write,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bdlp_pkg::MS_W-1:0]           cfg_data
);

  logic                                 pressed_level;
  logic [bdlp_pkg::MS_W-1:0]            long_press_ms;

  logic                                 req_valid;
  logic [bdlp_pkg::OP_W-1:0]            req_op;
  logic [bdlp_pkg::RAW_BITS-1:0]        req_raw;
  logic [bdlp_pkg::MS_W-1:0]            req_dt;
  logic [bdlp_pkg::IDX_W-1:0]           req_idx;
  logic                                 req_advance;

  bdlp_pkg::ctrl_t                      ctrl   [bdlp_pkg::NUM_BUTTONS];
  bdlp_pkg::status_t                    status [bdlp_pkg::NUM_BUTTONS];
  logic [bdlp_pkg::NUM_BUTTONS-1:0]     sample;
  logic [bdlp_pkg::RAW_BITS-1:0]        stable_after;
  logic                                 answer;
  logic                                 idx_bad;

  assign req_advance = req_valid && (!out_valid || out_ready);
  assign in_ready    = !req_valid || req_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_level <= bdlp_pkg::PRESSED_LEVEL_RESET;
      long_press_ms <= bdlp_pkg::LONG_PRESS_MS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bdlp_pkg::REG_PRESSED_LEVEL: pressed_level <= cfg_data[0];
        bdlp_pkg::REG_LONG_PRESS_MS: long_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op  <= op;
      req_raw <= raw_levels;
      req_dt  <= elapsed_ms;
      req_idx <= button_index;
    end
  end

  genvar g;
  generate
    for (g = 0; g < bdlp_pkg::NUM_BUTTONS; g++) begin : g_btn
      if (g < bdlp_pkg::RAW_BITS) begin : g_raw
        assign sample[g] = req_raw[g];
      end else begin : g_zero
        assign sample[g] = 1'b0;
      end
      bdlp_button u_button (
        .clk           (clk),
        .rst           (rst),
        .step          (req_advance),
        .sample        (sample[g]),
        .pressed_level (pressed_level),
        .long_press_ms (long_press_ms),
        .elapsed_ms    (req_dt),
        .ctrl          (ctrl[g]),
        .status        (status[g])
      );
    end
    for (g = 0; g < bdlp_pkg::RAW_BITS; g++) begin : g_lvl
      if (g < bdlp_pkg::NUM_BUTTONS) begin : g_have
        assign stable_after[g] = status[g].stable_next;
      end else begin : g_none
        assign stable_after[g] = 1'b0;
      end
    end
  endgenerate

  always_comb begin
    answer  = 1'b0;
    idx_bad = ((req_op == bdlp_pkg::OP_READ_PRESS) || (req_op == bdlp_pkg::OP_READ_LONG))
              && !(int'(req_idx) < bdlp_pkg::NUM_BUTTONS);
    for (int i = 0; i < bdlp_pkg::NUM_BUTTONS; i++) begin
      ctrl[i].tick        = (req_op == bdlp_pkg::OP_TICK);
      ctrl[i].clear_press = (req_op == bdlp_pkg::OP_READ_PRESS)
                            && (int'(req_idx) == i) && status[i].press_flag;
      ctrl[i].clear_long  = (req_op == bdlp_pkg::OP_READ_LONG)
                            && (int'(req_idx) == i) && status[i].long_flag
                            && (status[i].stable == pressed_level);
      answer = answer | ctrl[i].clear_press | ctrl[i].clear_long;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_advance) begin
      flag_answer   <= answer;
      index_error   <= idx_bad;
      stable_levels <= stable_after;
    end
  end

`ifndef ASSERT_OFF
  a_error_no_answer: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> !flag_answer)
    else $error("index error reported together with a set flag");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> req_valid && out_valid && !out_ready)
    else $error("request refused while the pipeline has room");

  a_tick_gives_no_flag: assert property (@(posedge clk) disable iff (rst)
    req_advance && (req_op == bdlp_pkg::OP_TICK) |=> !flag_answer && !index_error)
    else $error("tick request produced a flag or an error");
`endif

endmodule
